>>> hw/rtl/ptt_pkg.sv
// Shared constants, codes and control types of the periodic timer table.
package ptt_pkg;

	// Default table depth and time width.
	localparam int NUM_TIMERS_DEF = 16;
	localparam int TIME_BITS_DEF  = 48;

	// Request commands.
	typedef enum logic [1:0] {
		CMD_ADD    = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_TICK   = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_e;

	// Result kinds.
	typedef enum logic [2:0] {
		KIND_FIRED     = 3'd0,
		KIND_ADDED     = 3'd1,
		KIND_FULL      = 3'd2,
		KIND_REMOVED   = 3'd3,
		KIND_NOT_FOUND = 3'd4,
		KIND_TICK_DONE = 3'd5
	} kind_e;

	// Control from the sequencer to the shared divide and multiply unit.
	typedef struct packed {
		logic start;
		logic div;
	} arith_req_t;

endpackage

>>> hw/rtl/ptt_item_if.sv
// Request channel carrying one command to the timer table.
interface ptt_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [31:0] period;
	logic [31:0] repeat_req;
	logic        forever_req;
	logic [15:0] timer_id;
	logic [7:0]  advance;

	modport source (output valid, cmd, period, repeat_req, forever_req, timer_id, advance,
		input ready);
	modport sink (input valid, cmd, period, repeat_req, forever_req, timer_id, advance,
		output ready);
endinterface

>>> hw/rtl/ptt_result_if.sv
// Result channel carrying one answer of the timer table.
interface ptt_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [15:0] id_out;
	logic [31:0] fire_count;
	logic        finished;
	logic        last;

	modport source (output valid, kind, id_out, fire_count, finished, last, input ready);
	modport sink (input valid, kind, id_out, fire_count, finished, last, output ready);
endinterface

>>> hw/rtl/ptt_cfg_if.sv
// Configuration write channel for the fire lead register.
interface ptt_cfg_if;
	logic       valid;
	logic       ready;
	logic [3:0] fire_lead;

	modport source (output valid, fire_lead, input ready);
	modport sink (input valid, fire_lead, output ready);
endinterface

>>> hw/rtl/ptt_arith.sv
// Shared bit-serial unit: restoring divide and shift-add multiply on one adder.
module ptt_arith #(
	parameter int TIME_BITS = ptt_pkg::TIME_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ptt_pkg::arith_req_t    req,
	input  logic [TIME_BITS-1:0]   a,
	input  logic [31:0]            b,
	output logic                   done,
	output logic [TIME_BITS-1:0]   result
);

	localparam int AW    = TIME_BITS + 2;
	localparam int STEPW = $clog2(TIME_BITS);

	logic                 busy_q;
	logic                 div_q;
	logic                 done_q;
	logic [STEPW-1:0]     step_q;
	logic [31:0]          rem_q;
	logic [TIME_BITS-1:0] acc_q;
	logic [TIME_BITS-1:0] m_q;
	logic [31:0]          b_q;

	logic [32:0]   trial;
	logic [AW-1:0] op_x;
	logic [AW-1:0] op_y;
	logic [AW-1:0] sum;
	logic          ge;

	// One adder serves both operations: trial subtract or partial product add.
	always_comb begin
		trial = {rem_q, acc_q[TIME_BITS-1]};
		if (div_q) begin
			op_x = AW'(trial);
			op_y = ~AW'(b_q);
		end else begin
			op_x = AW'({acc_q[TIME_BITS-2:0], 1'b0});
			op_y = b_q[31] ? AW'(m_q) : '0;
		end
		sum = op_x + op_y + AW'(div_q);
		ge  = !sum[AW-1];
	end

	// Control of the step sequence.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			div_q  <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				div_q  <= req.div;
				step_q <= req.div ? STEPW'(TIME_BITS - 1) : STEPW'(31);
			end else if (busy_q) begin
				step_q <= step_q - STEPW'(1);
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: in divide the dividend shifts out while quotient bits shift in; in multiply partial products accumulate.
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			acc_q <= req.div ? a : '0;
			m_q   <= a;
			b_q   <= b;
		end else if (busy_q) begin
			if (div_q) begin
				rem_q <= ge ? sum[31:0] : trial[31:0];
				acc_q <= {acc_q[TIME_BITS-2:0], ge};
			end else begin
				acc_q <= sum[TIME_BITS-1:0];
				b_q   <= {b_q[30:0], 1'b0};
			end
		end
	end

	assign done   = done_q;
	assign result = acc_q;

endmodule

>>> hw/rtl/periodic_timer_table_top.sv
// Periodic timer table: command sequencer, entry memory and result register.
// An add goes to the reply state at once; a remove reads and checks each entry searched in turn.
// A tick reads and checks each entry; a due entry goes through a divide, a count update
// and a multiply on the shared bit-serial divide and multiply unit, then emits its result,
// and a finished timer is then removed by moving the last entry into its place.
// Reset clears time, count, identifier and fire lead; table entries are valid by count.
module periodic_timer_table_top #(
	parameter int NUM_TIMERS = ptt_pkg::NUM_TIMERS_DEF,
	parameter int TIME_BITS  = ptt_pkg::TIME_BITS_DEF
) (
	input logic             clk,
	input logic             arst_n,
	ptt_item_if.sink        items,
	ptt_result_if.source    results,
	ptt_cfg_if.sink         cfg
);

	localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int CW = $clog2(NUM_TIMERS + 1);

	typedef struct packed {
		logic [15:0]          ident;
		logic [31:0]          period;
		logic [TIME_BITS-1:0] start;
		logic [TIME_BITS-1:0] dl;
		logic [31:0]          count;
		logic [31:0]          lim;
		logic                 endless;
	} entry_t;

	typedef enum logic [11:0] {
		S_IDLE    = 12'b0000_0000_0001,
		S_REPLY   = 12'b0000_0000_0010,
		S_RM_RD   = 12'b0000_0000_0100,
		S_RM_CHK  = 12'b0000_0000_1000,
		S_MV_RD   = 12'b0000_0001_0000,
		S_MV_WR   = 12'b0000_0010_0000,
		S_TK_RD   = 12'b0000_0100_0000,
		S_TK_CHK  = 12'b0000_1000_0000,
		S_TK_DIV  = 12'b0001_0000_0000,
		S_TK_CNT  = 12'b0010_0000_0000,
		S_TK_MUL  = 12'b0100_0000_0000,
		S_TK_EMIT = 12'b1000_0000_0000
	} state_t;

	state_t               state_q;
	logic [TIME_BITS-1:0] now_q;
	logic [CW-1:0]        total_q;
	logic [15:0]          next_id_q;
	logic [3:0]           lead_q;
	logic [CW-1:0]        n_q;
	logic [15:0]          id_q;
	logic                 is_tick_q;
	ptt_pkg::kind_e       rep_kind_q;
	logic [15:0]          rep_id_q;
	logic [31:0]          cnt_q;
	logic                 fin_q;
	entry_t               ent_q;
	entry_t               rdata_q;
	entry_t               entry_mem [NUM_TIMERS];

	logic                 out_valid_q;
	ptt_pkg::kind_e       out_kind_q;
	logic [15:0]          out_id_q;
	logic [31:0]          out_count_q;
	logic                 out_fin_q;
	logic                 out_last_q;

	logic                 accept;
	logic                 out_free;
	logic                 out_load;
	logic                 full;
	logic                 scan_end;
	logic [CW-1:0]        tot_m1;
	logic [31:0]          per_c;
	logic [31:0]          rep_c;
	logic [IW-1:0]        rd_addr;
	logic                 wr_en;
	logic [IW-1:0]        wr_addr;
	entry_t               wr_data;
	logic                 due;
	logic [31:0]          cnt_inc;
	logic [33:0]          cnt_p2;
	logic [31:0]          cnt_new;
	ptt_pkg::arith_req_t  ar_req;
	logic [TIME_BITS-1:0] ar_a;
	logic [31:0]          ar_b;
	logic                 ar_done;
	logic [TIME_BITS-1:0] ar_result;

	// Handshake and table status.
	assign items.ready = (state_q == S_IDLE);
	assign accept      = items.valid && items.ready;
	assign out_free    = !out_valid_q || results.ready;
	assign out_load    = out_free && ((state_q == S_REPLY) || (state_q == S_TK_EMIT));
	assign full        = (total_q == CW'(NUM_TIMERS));
	assign scan_end    = (n_q >= total_q);
	assign tot_m1      = total_q - CW'(1);
	assign per_c       = (items.period == '0) ? 32'd1 : items.period;
	assign rep_c       = (items.repeat_req == '0) ? 32'd1 : items.repeat_req;

	// Fire lead register.
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q <= '0;
		end else if (cfg.valid) begin
			lead_q <= cfg.fire_lead;
		end
	end

	// Due test and count update from the entry under examination.
	always_comb begin
		due     = ({1'b0, rdata_q.dl} <= ({1'b0, now_q} + (TIME_BITS + 1)'(lead_q)));
		cnt_inc = (ent_q.count != '1) ? ent_q.count + 32'd1 : ent_q.count;
		cnt_p2  = {2'b00, cnt_inc} + 34'd2;
		cnt_new = cnt_inc;
		if (cnt_p2 < ar_result) begin
			cnt_new = (ar_result > 33'h0_FFFF_FFFF) ? '1 : ar_result[31:0];
		end
	end

	// Requests to the shared arithmetic unit.
	always_comb begin
		ar_req = '0;
		ar_a   = now_q - rdata_q.start;
		ar_b   = rdata_q.period;
		if (state_q == S_TK_CHK && !scan_end && due) begin
			ar_req.start = 1'b1;
			ar_req.div   = 1'b1;
		end else if (state_q == S_TK_CNT) begin
			ar_req.start = 1'b1;
			ar_a         = TIME_BITS'({1'b0, cnt_q} + 33'd1);
			ar_b         = ent_q.period;
		end
	end

	ptt_arith #(
		.TIME_BITS(TIME_BITS)
	) u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ar_req),
		.a      (ar_a),
		.b      (ar_b),
		.done   (ar_done),
		.result (ar_result)
	);

	// Memory read address.
	always_comb begin
		rd_addr = n_q[IW-1:0];
		if (state_q == S_MV_RD) begin
			rd_addr = tot_m1[IW-1:0];
		end
	end

	// Memory write port.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = n_q[IW-1:0];
		wr_data = rdata_q;
		if (state_q == S_IDLE) begin
			wr_addr         = total_q[IW-1:0];
			wr_en           = accept && (items.cmd == ptt_pkg::CMD_ADD) && !full;
			wr_data.ident   = next_id_q;
			wr_data.period  = per_c;
			wr_data.start   = now_q;
			wr_data.dl      = now_q + TIME_BITS'(per_c);
			wr_data.count   = '0;
			wr_data.lim     = rep_c;
			wr_data.endless = items.forever_req;
		end else if (state_q == S_TK_MUL) begin
			wr_en         = ar_done;
			wr_data       = ent_q;
			wr_data.count = cnt_q;
			wr_data.dl    = ent_q.start + ar_result;
		end else if (state_q == S_MV_WR) begin
			wr_en = 1'b1;
		end
	end

	// Entry memory.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_mem[wr_addr] <= wr_data;
		end
		rdata_q <= entry_mem[rd_addr];
	end

	// Command sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			now_q       <= '0;
			total_q     <= '0;
			next_id_q   <= '0;
			n_q         <= '0;
			is_tick_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						n_q <= '0;
						case (ptt_pkg::cmd_e'(items.cmd))
							ptt_pkg::CMD_ADD: begin
								state_q <= S_REPLY;
								if (full) begin
									rep_kind_q <= ptt_pkg::KIND_FULL;
									rep_id_q   <= '0;
								end else begin
									rep_kind_q <= ptt_pkg::KIND_ADDED;
									rep_id_q   <= next_id_q;
									next_id_q  <= next_id_q + 16'd1;
									total_q    <= total_q + CW'(1);
								end
							end
							ptt_pkg::CMD_REMOVE: begin
								id_q      <= items.timer_id;
								is_tick_q <= 1'b0;
								state_q   <= S_RM_RD;
							end
							ptt_pkg::CMD_TICK: begin
								now_q     <= now_q + TIME_BITS'(items.advance);
								is_tick_q <= 1'b1;
								state_q   <= S_TK_RD;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_REPLY: begin
					if (out_free) begin
						out_kind_q  <= rep_kind_q;
						out_id_q    <= rep_id_q;
						out_count_q <= '0;
						out_fin_q   <= 1'b0;
						out_last_q  <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				S_RM_RD: begin
					if (scan_end) begin
						rep_kind_q <= ptt_pkg::KIND_NOT_FOUND;
						rep_id_q   <= id_q;
						state_q    <= S_REPLY;
					end else begin
						state_q <= S_RM_CHK;
					end
				end
				S_RM_CHK: begin
					if (rdata_q.ident == id_q) begin
						state_q <= S_MV_RD;
					end else begin
						n_q     <= n_q + CW'(1);
						state_q <= S_RM_RD;
					end
				end
				S_MV_RD: begin
					state_q <= S_MV_WR;
				end
				S_MV_WR: begin
					total_q <= tot_m1;
					if (is_tick_q) begin
						n_q     <= n_q + CW'(1);
						state_q <= S_TK_RD;
					end else begin
						rep_kind_q <= ptt_pkg::KIND_REMOVED;
						rep_id_q   <= id_q;
						state_q    <= S_REPLY;
					end
				end
				S_TK_RD: begin
					if (scan_end) begin
						rep_kind_q <= ptt_pkg::KIND_TICK_DONE;
						rep_id_q   <= '0;
						state_q    <= S_REPLY;
					end else begin
						state_q <= S_TK_CHK;
					end
				end
				S_TK_CHK: begin
					ent_q <= rdata_q;
					if (due) begin
						state_q <= S_TK_DIV;
					end else begin
						n_q     <= n_q + CW'(1);
						state_q <= S_TK_RD;
					end
				end
				S_TK_DIV: begin
					if (ar_done) begin
						cnt_q   <= cnt_new;
						state_q <= S_TK_CNT;
					end
				end
				S_TK_CNT: begin
					state_q <= S_TK_MUL;
				end
				S_TK_MUL: begin
					if (ar_done) begin
						fin_q   <= !ent_q.endless && (cnt_q >= ent_q.lim);
						state_q <= S_TK_EMIT;
					end
				end
				S_TK_EMIT: begin
					if (out_free) begin
						out_kind_q  <= ptt_pkg::KIND_FIRED;
						out_id_q    <= ent_q.ident;
						out_count_q <= cnt_q;
						out_fin_q   <= fin_q;
						out_last_q  <= 1'b0;
						if (fin_q) begin
							state_q <= S_MV_RD;
						end else begin
							n_q     <= n_q + CW'(1);
							state_q <= S_TK_RD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result register drives the result channel.
	assign results.valid      = out_valid_q;
	assign results.kind       = out_kind_q;
	assign results.id_out     = out_id_q;
	assign results.fire_count = out_count_q;
	assign results.finished   = out_fin_q;
	assign results.last       = out_last_q;

	// The fill count never passes the table depth.
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= CW'(NUM_TIMERS))
		else $error("entry count exceeds table depth");

	// A move of the last entry shrinks the table by exactly one.
	a_move_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MV_WR |=> total_q == $past(tot_m1))
		else $error("entry move did not shrink the table");

	// An add into a full table stores nothing and keeps the identifier.
	a_full_add: assert property (@(posedge clk) disable iff (!arst_n)
		accept && items.cmd == ptt_pkg::CMD_ADD && full |=>
		$stable(total_q) && $stable(next_id_q))
		else $error("add into full table changed state");

	// The arithmetic unit is only started during a tick.
	a_arith_tick: assert property (@(posedge clk) disable iff (!arst_n)
		ar_req.start |-> is_tick_q)
		else $error("arithmetic unit started outside a tick");

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the periodic timer table: directed and random tests.
module testbench;

	localparam int SLOTS  = ptt_pkg::NUM_TIMERS_DEF;
	localparam int TBITS  = ptt_pkg::TIME_BITS_DEF;
	localparam logic [63:0] TIME_MASK = (64'd1 << TBITS) - 64'd1;
	localparam logic [63:0] CNT_MAX   = 64'hFFFF_FFFF;

	typedef struct {
		ptt_pkg::kind_e kind;
		logic [15:0]    ident;
		logic [31:0]    count;
		logic           finished;
		logic           last;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   errors = 0;

	ptt_item_if   items ();
	ptt_result_if results ();
	ptt_cfg_if    cfg ();

	periodic_timer_table_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.items  (items),
		.results(results),
		.cfg    (cfg)
	);

	always #4 clk = ~clk;

	// Shadow copy of the timer table.
	logic [3:0]  lead_ticks;
	logic [63:0] now_ticks;
	int          timer_count;
	logic [15:0] id_next;
	logic [15:0] slot_id    [SLOTS];
	logic [63:0] slot_period[SLOTS];
	logic [63:0] slot_begin [SLOTS];
	logic [63:0] slot_due   [SLOTS];
	logic [63:0] slot_fired [SLOTS];
	logic [63:0] slot_limit [SLOTS];
	logic        slot_endless[SLOTS];

	answer_t pending_answers[$];
	bit      sender_gaps = 1'b1;

	task automatic report(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		errors++;
	endtask

	task automatic expect_answer(input ptt_pkg::kind_e k, input logic [15:0] id,
			input logic [31:0] c, input logic fin, input logic lst);
		answer_t a;
		a.kind = k; a.ident = id; a.count = c; a.finished = fin; a.last = lst;
		pending_answers = {pending_answers, a};
	endtask

	task automatic move_last_into(input int n);
		int t;
		t = timer_count - 1;
		slot_id[n] = slot_id[t];
		slot_period[n] = slot_period[t];
		slot_begin[n] = slot_begin[t];
		slot_due[n] = slot_due[t];
		slot_fired[n] = slot_fired[t];
		slot_limit[n] = slot_limit[t];
		slot_endless[n] = slot_endless[t];
		timer_count = t;
	endtask

	// Works out the answers of one accepted request and updates the shadow table.
	task automatic predict_timer_table(input ptt_pkg::cmd_e c, input logic [31:0] per,
			input logic [31:0] rep, input logic fv, input logic [15:0] id,
			input logic [7:0] adv);
		logic [63:0] p, cnt, behind;
		logic        fin;
		bit          hit;
		int          n;
		case (c)
			ptt_pkg::CMD_ADD: begin
				if (timer_count >= SLOTS) begin
					expect_answer(ptt_pkg::KIND_FULL, 16'd0, 32'd0, 1'b0, 1'b1);
				end else begin
					n = timer_count;
					slot_id[n] = id_next;
					slot_period[n] = (per == 0) ? 64'd1 : 64'(per);
					slot_limit[n] = (rep == 0) ? 64'd1 : 64'(rep);
					slot_begin[n] = now_ticks;
					slot_due[n] = (now_ticks + slot_period[n]) & TIME_MASK;
					slot_fired[n] = 64'd0;
					slot_endless[n] = fv;
					timer_count++;
					expect_answer(ptt_pkg::KIND_ADDED, id_next, 32'd0, 1'b0, 1'b1);
					id_next++;
				end
			end
			ptt_pkg::CMD_REMOVE: begin
				hit = 1'b0;
				for (n = 0; n < timer_count && !hit; n++) begin
					if (slot_id[n] == id) begin
						move_last_into(n);
						hit = 1'b1;
					end
				end
				if (hit)
					expect_answer(ptt_pkg::KIND_REMOVED, id, 32'd0, 1'b0, 1'b1);
				else
					expect_answer(ptt_pkg::KIND_NOT_FOUND, id, 32'd0, 1'b0, 1'b1);
			end
			ptt_pkg::CMD_TICK: begin
				now_ticks = (now_ticks + 64'(adv)) & TIME_MASK;
				for (n = 0; n < timer_count; n++) begin
					if (slot_due[n] <= now_ticks ||
							slot_due[n] - now_ticks <= 64'(lead_ticks)) begin
						p = (slot_period[n] == 0) ? 64'd1 : slot_period[n];
						cnt = slot_fired[n];
						if (cnt < CNT_MAX) cnt++;
						behind = ((now_ticks - slot_begin[n]) & TIME_MASK) / p;
						// A timer that fell far behind catches up to where it should be.
						if (cnt + 2 < behind) cnt = (behind > CNT_MAX) ? CNT_MAX : behind;
						slot_fired[n] = cnt;
						slot_due[n] = (slot_begin[n] + (cnt + 1) * p) & TIME_MASK;
						fin = !slot_endless[n] && cnt >= slot_limit[n];
						expect_answer(ptt_pkg::KIND_FIRED, slot_id[n], cnt[31:0], fin, 1'b0);
						if (fin) move_last_into(n);
					end
				end
				expect_answer(ptt_pkg::KIND_TICK_DONE, 16'd0, 32'd0, 1'b0, 1'b1);
			end
			default: ;
		endcase
	endtask

	// Checks every accepted result against the oldest expectation.
	always @(posedge clk) begin
		answer_t a;
		if (arst_n && results.valid && results.ready) begin
			if (pending_answers.size() == 0) begin
				report($sformatf("unexpected result kind %0d id %0d", results.kind,
					results.id_out));
			end else begin
				a = pending_answers.pop_front();
				if (results.kind !== a.kind)
					report($sformatf("kind %0d, want %0d", results.kind, a.kind));
				if (results.id_out !== a.ident)
					report($sformatf("id %0d, want %0d", results.id_out, a.ident));
				if (results.fire_count !== a.count)
					report($sformatf("count %0d, want %0d", results.fire_count, a.count));
				if (results.finished !== a.finished)
					report($sformatf("finished %b, want %b", results.finished, a.finished));
				if (results.last !== a.last)
					report($sformatf("last %b, want %b", results.last, a.last));
			end
		end
	end

	// Receiver back-pressure.
	always @(negedge clk) begin
		int r;
		r = $urandom_range(99);
		if (r < 70) results.ready <= 1'b1;
		else if (r < 97) results.ready <= 1'b0;
		else results.ready <= ($urandom_range(3) == 0);
	end

	task automatic idle_gap();
		int r;
		r = $urandom_range(99);
		if (!sender_gaps || r < 60) return;
		repeat (r < 92 ? $urandom_range(1, 3) : $urandom_range(10, 60)) @(negedge clk);
	endtask

	// Sends one request and predicts its answers once it is taken.
	task automatic send_request(input ptt_pkg::cmd_e c, input logic [31:0] per,
			input logic [31:0] rep, input logic fv, input logic [15:0] id,
			input logic [7:0] adv);
		items.valid = 1'b1;
		items.cmd = c; items.period = per; items.repeat_req = rep;
		items.forever_req = fv; items.timer_id = id; items.advance = adv;
		do @(posedge clk); while (!items.ready);
		predict_timer_table(c, per, rep, fv, id, adv);
		@(negedge clk);
		items.valid = 1'b0;
		idle_gap();
	endtask

	task automatic add_timer(input logic [31:0] per, input logic [31:0] rep, input logic fv);
		send_request(ptt_pkg::CMD_ADD, per, rep, fv, 16'($urandom), 8'($urandom));
	endtask

	task automatic remove_timer(input logic [15:0] id);
		send_request(ptt_pkg::CMD_REMOVE, $urandom, $urandom, 1'($urandom), id, 8'($urandom));
	endtask

	task automatic tick(input logic [7:0] adv);
		send_request(ptt_pkg::CMD_TICK, $urandom, $urandom, 1'($urandom), 16'($urandom), adv);
	endtask

	task automatic wait_drained();
		while (pending_answers.size() != 0) @(negedge clk);
		repeat (64) @(negedge clk);
	endtask

	// Writes the fire lead while the table is idle.
	task automatic set_fire_lead(input logic [3:0] v);
		wait_drained();
		cfg.valid = 1'b1;
		cfg.fire_lead = v;
		do @(posedge clk); while (!cfg.ready);
		lead_ticks = v;
		@(negedge clk);
		cfg.valid = 1'b0;
	endtask

	// Extremes of the fields, every command and the named corner cases.
	task automatic test_directed();
		add_timer(32'd0, 32'd0, 1'b0);
		add_timer(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		add_timer(32'd1, 32'd3, 1'b0);
		add_timer(32'd3, 32'd2, 1'b0);
		tick(8'd0);
		tick(8'd1);
		tick(8'd255);
		send_request(ptt_pkg::CMD_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 8'hFF);
		remove_timer(16'hFFFF);
		remove_timer(16'd1);
		set_fire_lead(4'd15);
		add_timer(32'd20, 32'd5, 1'b1);
		tick(8'd2);
		for (int i = 0; i < 16; i++) add_timer(32'($urandom_range(1, 9)), 32'd1, 1'b0);
		tick(8'd200);
		remove_timer(16'd1);
	endtask

	task automatic random_request();
		int r;
		logic [31:0] per, rep;
		r = $urandom_range(99);
		if (r < 35) begin
			per = ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(0, 24));
			rep = ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(0, 6));
			add_timer(per, rep, $urandom_range(3) == 0);
		end else if (r < 50) begin
			if (timer_count > 0 && $urandom_range(3) != 0)
				remove_timer(slot_id[$urandom_range(timer_count - 1)]);
			else
				remove_timer(16'($urandom));
		end else if (r < 97) begin
			tick(($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12)));
		end else begin
			send_request(ptt_pkg::CMD_NONE, $urandom, $urandom, 1'($urandom),
				16'($urandom), 8'($urandom));
		end
	endtask

	// Random traffic under several fire lead settings, each written after a full drain, plus one mid-run drain.
	task automatic test_random();
		logic [3:0] leads[4];
		leads = '{4'd0, 4'd15, 4'($urandom), 4'($urandom)};
		foreach (leads[i]) begin
			set_fire_lead(leads[i]);
			repeat (45) random_request();
			sender_gaps = 1'b0;
			repeat (20) random_request();
			sender_gaps = 1'b1;
			if (i == 1) begin
				while (pending_answers.size() != 0) @(negedge clk);
			end
			repeat (30) random_request();
		end
	endtask

	initial begin
		items.valid = 1'b0; items.cmd = ptt_pkg::CMD_NONE; items.period = '0;
		items.repeat_req = '0;
		items.forever_req = 1'b0; items.timer_id = '0; items.advance = '0;
		cfg.valid = 1'b0; cfg.fire_lead = '0;
		results.ready = 1'b0;
		lead_ticks = '0; now_ticks = '0; timer_count = 0; id_next = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random();
		wait_drained();
		if (errors == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end

	initial begin
		#80_000_000;
		$display("TB_ERROR");
		$finish;
	end
endmodule
